@@ design/u2cp_pkg.sv @@
// Shared types and constants for the UTF-8 to code point decoder.
package u2cp_pkg;

	localparam int unsigned CP_W = 21;
	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

	// Decoder state carried between items
	typedef struct packed {
		logic [CP_W-1:0] partial;
		logic [1:0]      remaining;
	} u2cp_state_t;

	// Outcome of one byte
	typedef struct packed {
		logic            emit;
		logic [CP_W-1:0] cp;
		logic            bad;
	} u2cp_result_t;

endpackage

@@ design/utf8_to_codepoint_decoder.sv @@
// Top level of the UTF-8 to code point decoder: input stage, state and result register.
// Path: an accepted byte's result passes the input register, then the result register,
//   before it shows on out_valid.
// Throughput: one byte per cycle unless the output stalls; the decode of one byte is
//   a single pass of logic between the input register and the result register.
// Reset: arst_n clears the valid bits and the pending sequence; payload is not reset.
module utf8_to_codepoint_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [20:0] char_code,
	output logic        malformed
);

	// Input register
	logic       vld_s1;
	logic [7:0] byte_s1;

	// Decoder state: gathered payload bits and continuation bytes still expected
	u2cp_pkg::u2cp_state_t state_q;
	u2cp_pkg::u2cp_state_t state_nxt;
	u2cp_pkg::u2cp_result_t res;

	// Result register
	logic                      vld_s2;
	logic [u2cp_pkg::CP_W-1:0] cp_s2;
	logic                      bad_s2;

	logic out_load;   // result register may take a new value
	logic consume;    // item in the input register is decoded this cycle
	logic accept;

	assign out_load = !vld_s2 || !out_stall;
	assign consume  = vld_s1 && out_load;
	// Input stage only holds when its item cannot move into the result register
	assign in_stall = vld_s1 && !out_load;
	assign accept   = in_valid && !in_stall;

	u2cp_step u_step (
		.in_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (consume) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
		end
	end

	// Sequence state advances once per decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (consume) begin
			state_q <= state_nxt;
		end
	end

	// Well-formed lead bytes and non-final continuations produce no item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_load) begin
			vld_s2 <= consume && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && res.emit) begin
			cp_s2  <= res.cp;
			bad_s2 <= res.bad;
		end
	end

	assign out_valid = vld_s2;
	assign char_code = cp_s2;
	assign malformed = bad_s2;

endmodule

@@ design/u2cp_step.sv @@
// Combinational next-state and result logic for one input byte.
module u2cp_step (
	input  logic [7:0]           in_byte,
	input  u2cp_pkg::u2cp_state_t cur,
	output u2cp_pkg::u2cp_state_t nxt,
	output u2cp_pkg::u2cp_result_t res
);

	logic       pending;
	logic [1:0] rem_dec;
	logic [u2cp_pkg::CP_W-1:0] shifted;

	assign pending = (cur.remaining != 2'd0);
	assign rem_dec = cur.remaining - 2'd1;
	assign shifted = {cur.partial[u2cp_pkg::CP_W-7:0], in_byte[5:0]};

	always_comb begin
		nxt      = cur;
		res.emit = 1'b0;
		res.cp   = u2cp_pkg::REPLACEMENT_CP;
		res.bad  = 1'b0;
		if (!in_byte[7]) begin
			// ASCII: passes through, pending sequence untouched
			res.emit = 1'b1;
			res.cp   = {{(u2cp_pkg::CP_W-8){1'b0}}, in_byte};
		end else if (in_byte[6] == 1'b0) begin
			// continuation byte
			if (pending) begin
				nxt.remaining = rem_dec;
				if (rem_dec == 2'd0) begin
					nxt.partial = '0;
					res.emit    = 1'b1;
					res.cp      = shifted;
				end else begin
					nxt.partial = shifted;
				end
			end else begin
				res.emit = 1'b1;
				res.bad  = 1'b1;
			end
		end else if (pending || (in_byte[7:3] == 5'b11111)) begin
			// lead mid-sequence or too many leading ones
			nxt      = '0;
			res.emit = 1'b1;
			res.bad  = 1'b1;
		end else if (in_byte[5] == 1'b0) begin
			nxt.partial   = {{(u2cp_pkg::CP_W-5){1'b0}}, in_byte[4:0]};
			nxt.remaining = 2'd1;
		end else if (in_byte[4] == 1'b0) begin
			nxt.partial   = {{(u2cp_pkg::CP_W-4){1'b0}}, in_byte[3:0]};
			nxt.remaining = 2'd2;
		end else begin
			nxt.partial   = {{(u2cp_pkg::CP_W-3){1'b0}}, in_byte[2:0]};
			nxt.remaining = 2'd3;
		end
	end

endmodule

@@ design/u2cp_chk.sv @@
// Port-level checker for the UTF-8 to code point decoder, bound to the top level.
module u2cp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  in_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [20:0] char_code,
	input logic        malformed
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(malformed))
		else $error("stalled result changed");

	// Replacement items always carry U+FFFD
	a_bad_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && malformed |-> char_code == 21'h00FFFD)
		else $error("malformed item without replacement code point");

	// Input only held back when the result register is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free result register");

	// ASCII byte comes out as itself through the input and result registers when the output flows
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !in_byte[7]) ##1 !out_stall |=>
		out_valid && !malformed && char_code == {13'd0, $past(in_byte, 2)})
		else $error("ASCII byte not passed through");

endmodule

bind utf8_to_codepoint_decoder u2cp_chk u_chk (.*);
